[rtl/modbus_rtu_response_checker_defines.svh]
// Assertion macros used by the RTL checker module.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define MBRC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define MBRC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mbrc_pkg.sv]
package mbrc_pkg;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_WRONG     = 2'd1,
        STATUS_CRC       = 2'd2,
        STATUS_EXCEPTION = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [1:0] REG_SLAVE_ADDRESS     = 2'd0;
    localparam logic [1:0] REG_EXPECTED_FUNCTION = 2'd1;
    localparam logic [1:0] REG_EXPECTED_LENGTH   = 2'd2;

    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [7:0]  EXC_BIT         = 8'h80;
    localparam logic [6:0]  FC_READ_HOLDING = 7'h03;
    localparam int          MIN_LEN         = 5;

    localparam logic [7:0]  RST_SLAVE_ADDRESS     = 8'd1;
    localparam logic [6:0]  RST_EXPECTED_FUNCTION = 7'd3;
    localparam logic [7:0]  RST_EXPECTED_LENGTH   = 8'd0;

    // Byte-parallel Modbus CRC-16 update, reflected polynomial
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/modbus_rtu_response_checker.sv]
// A frame's status is registered at its frame-end transfer into the result
// register, or the skid register if that is full. Throughput: one byte per cycle
// while skid is empty, set by the byte-parallel CRC update; a two-entry output
// (result register plus skid register) keeps s_tready high while one status waits.
// Reset (aresetn low, synchronous): registers to 1 / 3 / 0, CRC to 0xFFFF,
// count and captured bytes to zero, output empty.
`include "modbus_rtu_response_checker_defines.svh"

module modbus_rtu_response_checker #(
    parameter int MAX_FRAME = 256
) (
    input  logic       aclk,
    input  logic       aresetn,

    // Configuration write port
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,

    // Received bytes
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       s_tlast,   // frame_end

    // Frame status
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] status, [7:2] zero
);

    // Count must hold MAX_FRAME itself, where it saturates
    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    // Configuration registers
    logic [7:0] slave_address_reg;
    logic [6:0] expected_function_reg;
    logic [7:0] expected_length_reg;

    // Frame state
    logic [15:0]      crc_reg,    crc_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [7:0]       byte0_reg,  byte0_next;
    logic [7:0]       byte1_reg,  byte1_next;
    logic [7:0]       byte2_reg,  byte2_next;

    // Output register and skid register
    logic                  out_valid_reg,  out_valid_next;
    mbrc_pkg::status_t     out_status_reg, out_status_next;
    logic                  skid_valid_reg, skid_valid_next;
    mbrc_pkg::status_t     skid_status_reg, skid_status_next;

    logic              in_xfer;
    logic              out_xfer;
    logic              room;
    logic [15:0]       crc_upd;
    logic [CNT_W-1:0]  count_upd;
    logic [CNT_W-1:0]  count_minus2;
    mbrc_pkg::status_t status;

    assign s_tready = !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_status_reg};

    // Configuration writes; an index beyond the list is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg     <= mbrc_pkg::RST_SLAVE_ADDRESS;
            expected_function_reg <= mbrc_pkg::RST_EXPECTED_FUNCTION;
            expected_length_reg   <= mbrc_pkg::RST_EXPECTED_LENGTH;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mbrc_pkg::REG_SLAVE_ADDRESS:     slave_address_reg     <= cfg_wdata;
                mbrc_pkg::REG_EXPECTED_FUNCTION: expected_function_reg <= cfg_wdata[6:0];
                mbrc_pkg::REG_EXPECTED_LENGTH:   expected_length_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance CRC and count only while the receive buffer has room;
    // bytes past MAX_FRAME are dropped up to the frame end.
    always_comb begin
        room      = (count_reg < CNT_W'(MAX_FRAME));
        crc_upd   = room ? mbrc_pkg::crc_byte(crc_reg, s_tdata) : crc_reg;
        count_upd = room ? count_reg + CNT_W'(1) : count_reg;
    end

    // Frame state next value: capture the header bytes, clear after frame end
    always_comb begin
        crc_next   = crc_reg;
        count_next = count_reg;
        byte0_next = byte0_reg;
        byte1_next = byte1_reg;
        byte2_next = byte2_reg;
        if (in_xfer) begin
            if (s_tlast) begin
                crc_next   = mbrc_pkg::CRC_INIT;
                count_next = '0;
                byte0_next = '0;
                byte1_next = '0;
                byte2_next = '0;
            end else begin
                crc_next   = crc_upd;
                count_next = count_upd;
                if (room) begin
                    if (count_reg == CNT_W'(0)) byte0_next = s_tdata;
                    if (count_reg == CNT_W'(1)) byte1_next = s_tdata;
                    if (count_reg == CNT_W'(2)) byte2_next = s_tdata;
                end
            end
        end
    end

    // Judge the frame from the updated CRC and count. A frame that ends before
    // its third byte is too short, so the captured bytes are always settled here.
    assign count_minus2 = count_upd - CNT_W'(2);

    always_comb begin
        priority if (count_upd < CNT_W'(mbrc_pkg::MIN_LEN)) begin
            status = mbrc_pkg::STATUS_WRONG;
        end else if (crc_upd != 16'h0000) begin
            status = mbrc_pkg::STATUS_CRC;
        end else if (byte0_reg != slave_address_reg) begin
            status = mbrc_pkg::STATUS_WRONG;
        end else if (byte1_reg == (mbrc_pkg::EXC_BIT | {1'b0, expected_function_reg})) begin
            status = mbrc_pkg::STATUS_EXCEPTION;
        end else if (byte1_reg != {1'b0, expected_function_reg}) begin
            status = mbrc_pkg::STATUS_WRONG;
        end else if (expected_function_reg == mbrc_pkg::FC_READ_HOLDING) begin
            status = (byte2_reg == expected_length_reg) ? mbrc_pkg::STATUS_OK
                                                        : mbrc_pkg::STATUS_WRONG;
        end else begin
            status = (CMP_W'(count_minus2) == CMP_W'(expected_length_reg))
                     ? mbrc_pkg::STATUS_OK : mbrc_pkg::STATUS_WRONG;
        end
    end

    // Output queue: skid drains into the result register first, a new status
    // goes to whichever slot is free after the pop.
    always_comb begin
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        skid_valid_next  = skid_valid_reg;
        skid_status_next = skid_status_reg;
        if (out_xfer) begin
            out_valid_next  = skid_valid_reg;
            out_status_next = skid_status_reg;
            skid_valid_next = 1'b0;
        end
        if (in_xfer && s_tlast) begin
            if (!out_valid_next) begin
                out_valid_next  = 1'b1;
                out_status_next = status;
            end else begin
                skid_valid_next  = 1'b1;
                skid_status_next = status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg        <= mbrc_pkg::CRC_INIT;
            count_reg      <= '0;
            byte0_reg      <= '0;
            byte1_reg      <= '0;
            byte2_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            crc_reg        <= crc_next;
            count_reg      <= count_next;
            byte0_reg      <= byte0_next;
            byte1_reg      <= byte1_next;
            byte2_reg      <= byte2_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg  <= out_status_next;
        skid_status_reg <= skid_status_next;
    end

    `MBRC_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg, "skid holds a status while the result register is empty")
    `MBRC_ASSERT(a_end_gives_status, aclk, aresetn, (in_xfer && s_tlast) |=> m_tvalid, "frame end transfer gave no status")
    `MBRC_ASSERT(a_end_clears_frame, aclk, aresetn, (in_xfer && s_tlast) |=> (count_reg == '0 && crc_reg == mbrc_pkg::CRC_INIT), "frame state not cleared after frame end")
    `MBRC_ASSERT(a_count_bounded, aclk, aresetn, count_reg <= CNT_W'(MAX_FRAME), "byte count beyond MAX_FRAME")
    `MBRC_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> (!m_tvalid && count_reg == '0 && crc_reg == mbrc_pkg::CRC_INIT), "reset left frame state or output set")

endmodule
